// File: src/triangle_face_normal_segment_core_defines.svh
// Assertion macros shared by the triangle face normal segment RTL.
`ifndef TRIANGLE_FACE_NORMAL_SEGMENT_CORE_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_SEGMENT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TFN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tfn assertion failed");
`define TFN_NEVER(lbl, expr) \
    `TFN_ASSERT(lbl, !(expr))
`else
`define TFN_ASSERT(lbl, prop)
`define TFN_NEVER(lbl, expr)
`endif
`endif

// File: src/tfn_pkg.sv
// Shared types, widths and arithmetic helpers of the face normal pipeline.
`default_nettype none
package tfn_pkg;
    localparam int VERTEX_COUNT = 1024;
    localparam int AW  = 10;   // vertex slot
    localparam int CW  = 16;   // Q8.8 coordinate
    localparam int EW  = 17;   // edge component
    localparam int SUW = 18;   // sum of three coordinates
    localparam int PW  = 34;   // edge product
    localparam int XW  = 35;   // cross component
    localparam int MW  = 34;   // cross magnitude
    localparam int POSW = 6;   // bit position within a magnitude
    localparam int NW  = 30;   // normalized magnitude
    localparam int QSW = 60;   // square of a normalized magnitude
    localparam int SQW = 64;   // square root working width
    localparam int SQ_TOP = 62;
    localparam int SQ_STAGES = 16;
    localparam int RW  = 31;   // square root result
    localparam int LW  = 16;   // magnitude of the segment length
    localparam int DW  = 47;   // divider working width
    localparam int QW  = 16;   // quotient
    localparam int DIV_STAGES = 8;
    localparam int DIV3_SHIFT = 18;
    localparam logic [16:0] DIV3_MUL = 17'd87382;
    localparam logic signed [CW-1:0] LEN_RESET = 16'sd512;

    typedef struct packed {
        logic [2:0][CW-1:0] center;
        logic [2:0][NW-1:0] mag;
        logic [2:0]         neg;
        logic               degen;
    } t_geom;

    typedef struct packed {
        logic [SQW-1:0] x;
        logic [SQW-1:0] res;
    } t_sq;

    typedef struct packed {
        logic [2:0][DW-1:0] rem;
        logic [2:0][QW-1:0] quo;
    } t_div;

    // One step of the digit-by-digit integer square root.
    function automatic t_sq sq_step(t_sq a, logic [SQW-1:0] b);
        t_sq r;
        if (a.x >= a.res + b) begin
            r.x   = a.x - (a.res + b);
            r.res = (a.res >> 1) + b;
        end else begin
            r.x   = a.x;
            r.res = a.res >> 1;
        end
        return r;
    endfunction

    // One restoring division step on all three lanes for quotient bit k.
    function automatic t_div div_step(t_div a, logic [RW-1:0] d, int k);
        t_div r;
        logic [DW-1:0] sh;
        r = a;
        sh = DW'(d) << k;
        for (int i = 0; i < 3; i++) begin
            if (a.rem[i] >= sh) begin
                r.rem[i] = a.rem[i] - sh;
                r.quo[i][k] = 1'b1;
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: src/tfn_geom.sv
// Vertex store, edges, cross product, centroid and magnitude normalization.
`default_nettype none
module tfn_geom
    import tfn_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic                i_req_type,
    input  wire logic [AW-1:0]       i_addr,
    input  wire logic [2:0][CW-1:0]  i_coord,
    input  wire logic [2:0][AW-1:0]  i_idx,
    output logic                     o_valid,
    output t_geom                    o_geom
);
    logic [3*CW-1:0] mem0 [VERTEX_COUNT];
    logic [3*CW-1:0] mem1 [VERTEX_COUNT];
    logic [3*CW-1:0] mem2 [VERTEX_COUNT];
    logic [3*CW-1:0] r_vtx [3];
    logic            r_v1, r_v2, r_v3, r_v4, r_v5;

    logic                  wr;
    assign wr = i_valid && !i_req_type;

    // Three copies of the store give one read port per triangle corner.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem0[i_addr] <= i_coord;
        end
        if (i_en) begin
            r_vtx[0] <= mem0[i_idx[0]];
        end
    end
    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem1[i_addr] <= i_coord;
        end
        if (i_en) begin
            r_vtx[1] <= mem1[i_idx[1]];
        end
    end
    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem2[i_addr] <= i_coord;
        end
        if (i_en) begin
            r_vtx[2] <= mem2[i_idx[2]];
        end
    end

    // Edges and coordinate sums.
    logic signed [EW-1:0]  r_e1 [3], r_e2 [3], n_e1 [3], n_e2 [3];
    logic signed [SUW-1:0] r_sum [3], n_sum [3];
    always_comb begin
        logic signed [CW-1:0] a, b, c;
        for (int i = 0; i < 3; i++) begin
            a = r_vtx[0][i*CW +: CW];
            b = r_vtx[1][i*CW +: CW];
            c = r_vtx[2][i*CW +: CW];
            n_e1[i]  = EW'(b) - EW'(a);
            n_e2[i]  = EW'(c) - EW'(a);
            n_sum[i] = SUW'(a) + SUW'(b) + SUW'(c);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
            r_sum <= n_sum;
        end
    end

    // Edge products and centroid (divide by three through a reciprocal).
    logic signed [PW-1:0] r_p [6], n_p [6];
    logic signed [CW-1:0] r_cen [3], n_cen [3];
    always_comb begin
        logic [SUW-2:0] am;
        logic [SUW+16:0] pr;
        logic [CW-1:0]   q;
        n_p[0] = r_e1[1] * r_e2[2];
        n_p[1] = r_e1[2] * r_e2[1];
        n_p[2] = r_e1[2] * r_e2[0];
        n_p[3] = r_e1[0] * r_e2[2];
        n_p[4] = r_e1[0] * r_e2[1];
        n_p[5] = r_e1[1] * r_e2[0];
        for (int i = 0; i < 3; i++) begin
            am = r_sum[i][SUW-1] ? (SUW-1)'(-r_sum[i]) : r_sum[i][SUW-2:0];
            pr = (SUW+17)'(am) * (SUW+17)'(DIV3_MUL);
            q  = pr[DIV3_SHIFT +: CW];
            n_cen[i] = r_sum[i][SUW-1] ? -$signed(q) : $signed(q);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
            r_cen <= n_cen;
        end
    end

    // Cross product as sign and magnitude.
    logic [MW-1:0] r_mag [3], n_mag [3];
    logic [2:0]    r_neg, n_neg;
    logic signed [CW-1:0] r_cen4 [3];
    always_comb begin
        logic signed [XW-1:0] cr;
        for (int i = 0; i < 3; i++) begin
            cr = XW'(r_p[2*i]) - XW'(r_p[2*i+1]);
            n_neg[i] = cr[XW-1];
            n_mag[i] = cr[XW-1] ? MW'(-cr) : MW'(cr);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
            r_neg <= n_neg;
            r_cen4 <= r_cen;
        end
    end

    // Largest magnitude and its leading one.
    logic [MW-1:0]   r_mag5 [3];
    logic [2:0]      r_neg5;
    logic signed [CW-1:0] r_cen5 [3];
    logic [POSW-1:0] r_pos, n_pos;
    logic            r_deg, n_deg;
    always_comb begin
        logic [MW-1:0] mx;
        mx = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
        mx = (mx > r_mag[2]) ? mx : r_mag[2];
        n_deg = (mx == '0);
        n_pos = '0;
        for (int b = 0; b < MW; b++) begin
            if (mx[b]) begin
                n_pos = POSW'(b);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag5 <= r_mag;
            r_neg5 <= r_neg;
            r_cen5 <= r_cen4;
            r_pos  <= n_pos;
            r_deg  <= n_deg;
        end
    end

    // Shift all magnitudes so the largest has its top bit at NW-1.
    t_geom n_geom;
    always_comb begin
        logic [MW-1:0] t;
        for (int i = 0; i < 3; i++) begin
            if (r_pos > POSW'(NW-1)) begin
                t = r_mag5[i] >> (r_pos - POSW'(NW-1));
            end else begin
                t = r_mag5[i] << (POSW'(NW-1) - r_pos);
            end
            n_geom.mag[i]    = t[NW-1:0];
            n_geom.center[i] = r_cen5[i];
        end
        n_geom.neg   = r_neg5;
        n_geom.degen = r_deg;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_geom <= n_geom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid && i_req_type;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            o_valid <= r_v5;
        end
    end
endmodule
`default_nettype wire

// File: src/tfn_isqrt.sv
// Sum of squares and a pipelined square root, two result bits per stage.
`default_nettype none
module tfn_isqrt
    import tfn_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_geom  i_geom,
    output logic        o_valid,
    output t_geom       o_geom,
    output logic [RW-1:0] o_root
);
    logic [QSW-1:0] r_sqr [3];
    t_geom          r_pay0;
    logic           r_vld0;
    t_sq            r_sq  [SQ_STAGES+1];
    t_geom          r_pay [SQ_STAGES+1];
    logic           r_vld [SQ_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sqr[i] <= QSW'(i_geom.mag[i]) * QSW'(i_geom.mag[i]);
            end
            r_pay0 <= i_geom;
            r_sq[0].x   <= SQW'(r_sqr[0]) + SQW'(r_sqr[1]) + SQW'(r_sqr[2]);
            r_sq[0].res <= '0;
            r_pay[0] <= r_pay0;
        end
    end

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[s+1] <= sq_step(sq_step(r_sq[s], SQW'(1) << (SQ_TOP - 4*s)),
                                     SQW'(1) << (SQ_TOP - 4*s - 2));
                r_pay[s+1] <= r_pay[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            for (int s = 0; s <= SQ_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld0 <= i_valid;
            r_vld[0] <= r_vld0;
            for (int s = 0; s < SQ_STAGES; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    assign o_valid = r_vld[SQ_STAGES];
    assign o_geom  = r_pay[SQ_STAGES];
    assign o_root  = r_sq[SQ_STAGES].res[RW-1:0];
endmodule
`default_nettype wire

// File: src/tfn_scale.sv
// Length scaling, pipelined division by the norm, tip add and saturation.
`default_nettype none
module tfn_scale
    import tfn_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire t_geom                i_geom,
    input  wire logic [RW-1:0]        i_root,
    input  wire logic signed [CW-1:0] i_len,
    output logic                      o_valid,
    output logic [2:0][CW-1:0]        o_center,
    output logic [2:0][CW-1:0]        o_tip,
    output logic                      o_degen
);
    t_div          r_dv  [DIV_STAGES+1];
    logic [RW-1:0] r_d   [DIV_STAGES+1];
    logic [2:0]    r_sgn [DIV_STAGES+1];
    t_geom         r_pay [DIV_STAGES+1];
    logic          r_vld [DIV_STAGES+1];

    logic [LW-1:0] lmag;
    logic          lneg;
    assign lneg = i_len[CW-1];
    assign lmag = lneg ? LW'(-i_len) : LW'(i_len);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv[0].rem[i] <= DW'(i_geom.mag[i]) * DW'(lmag);
                r_dv[0].quo[i] <= '0;
                r_sgn[0][i]    <= i_geom.neg[i] ^ lneg;
            end
            r_d[0]   <= i_root;
            r_pay[0] <= i_geom;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[s+1] <= div_step(div_step(r_dv[s], r_d[s], QW - 1 - 2*s), r_d[s],
                                      QW - 2 - 2*s);
                r_d[s+1]   <= r_d[s];
                r_sgn[s+1] <= r_sgn[s];
                r_pay[s+1] <= r_pay[s];
            end
        end
    end

    // Signed offset added to the centroid, clamped to the Q8.8 range.
    logic [2:0][CW-1:0] n_tip;
    always_comb begin
        logic signed [CW+1:0] sum;
        logic signed [CW+1:0] off;
        for (int i = 0; i < 3; i++) begin
            off = r_sgn[DIV_STAGES][i] ? -$signed((CW+2)'(r_dv[DIV_STAGES].quo[i]))
                                       : $signed((CW+2)'(r_dv[DIV_STAGES].quo[i]));
            sum = $signed((CW+2)'($signed(r_pay[DIV_STAGES].center[i]))) + off;
            if (r_pay[DIV_STAGES].degen) begin
                n_tip[i] = r_pay[DIV_STAGES].center[i];
            end else if (sum > (CW+2)'(32767)) begin
                n_tip[i] = 16'h7fff;
            end else if (sum < -(CW+2)'(32768)) begin
                n_tip[i] = 16'h8000;
            end else begin
                n_tip[i] = sum[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_center <= r_pay[DIV_STAGES].center;
            o_tip    <= n_tip;
            o_degen  <= r_pay[DIV_STAGES].degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
            o_valid <= r_vld[DIV_STAGES];
        end
    end
endmodule
`default_nettype wire

// File: src/triangle_face_normal_segment_core.sv
// Top level of the triangle centroid and face normal segment pipeline.
// m_axis_tvalid follows the input transfer through 34 register stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Most of the depth comes from the 16-stage square root and the 8-stage divider.
// Vertex writes give no result. Synchronous active-low reset clears the valid
// bits and sets the segment length to 2.0; the vertex store is not cleared.
`default_nettype none
`include "triangle_face_normal_segment_core_defines.svh"
module triangle_face_normal_segment_core
    import tfn_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // vertex_addr, coord_x, coord_y, coord_z, first_index, second_index, third_index
    input  wire logic [87:0]   s_axis_tdata,
    // req_type
    input  wire logic [0:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // center_x, center_y, center_z, tip_x, tip_y, tip_z
    output logic [95:0]        m_axis_tdata,
    // degenerate
    output logic [0:0]         m_axis_tuser,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [CW-1:0] i_cfg_data
);
    logic signed [CW-1:0] r_len;
    logic                 en, acc;
    logic [2:0][CW-1:0]   coord;
    logic [2:0][AW-1:0]   idx;
    logic                 g_valid, q_valid;
    t_geom                g_geom, q_geom;
    logic [RW-1:0]        root;
    logic [2:0][CW-1:0]   center, tip;
    logic                 degen;

    assign en  = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign acc = s_axis_tvalid && en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_valid) begin
            r_len <= i_cfg_data;
        end
    end

    assign coord = s_axis_tdata[57:10];
    assign idx   = s_axis_tdata[87:58];

    tfn_geom u_geom (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(acc), .i_req_type(s_axis_tuser[0]),
        .i_addr(s_axis_tdata[AW-1:0]), .i_coord(coord), .i_idx(idx),
        .o_valid(g_valid), .o_geom(g_geom)
    );

    tfn_isqrt u_isqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(g_valid), .i_geom(g_geom),
        .o_valid(q_valid), .o_geom(q_geom), .o_root(root)
    );

    tfn_scale u_scale (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(q_valid), .i_geom(q_geom),
        .i_root(root), .i_len(r_len), .o_valid(m_axis_tvalid),
        .o_center(center), .o_tip(tip), .o_degen(degen)
    );

    assign m_axis_tdata = {tip, center};
    assign m_axis_tuser = degen;

    `TFN_ASSERT(a_degen_tip, m_axis_tvalid && degen |-> tip == center)
    `TFN_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready)
    `TFN_NEVER(a_freeze_on_stall, m_axis_tvalid && !m_axis_tready && s_axis_tready)
endmodule
`default_nettype wire

// File: verif/tb_triangle_face_normal_segment_core.sv
// Testbench for the triangle centroid and face normal segment core.
module tb_triangle_face_normal_segment_core;
    import tfn_pkg::*;

    localparam logic REQ_VERTEX   = 1'b0;
    localparam logic REQ_TRIANGLE = 1'b1;
    localparam int   PIPE_DRAIN   = 60;
    localparam int   CYCLE_LIMIT  = 900000;

    typedef struct packed {
        logic [15:0] cx, cy, cz, tx, ty, tz;
        logic        degen;
    } t_face;

    class face_board;
        logic signed [15:0] vx[VERTEX_COUNT], vy[VERTEX_COUNT], vz[VERTEX_COUNT];
        logic signed [15:0] seg_len;
        t_face pending[$];
        int errors;

        function new();
            seg_len = LEN_RESET;
            errors = 0;
        endfunction

        function automatic longint unsigned root64(longint unsigned x);
            longint unsigned res, bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > x) bt >>= 2;
            while (bt != 0) begin
                if (x >= res + bt) begin
                    x -= res + bt;
                    res = (res >> 1) + bt;
                end else begin
                    res >>= 1;
                end
                bt >>= 2;
            end
            return res;
        endfunction

        function automatic logic [15:0] clip16(longint v);
            if (v > 32767) return 16'h7fff;
            if (v < -32768) return 16'h8000;
            return v[15:0];
        endfunction

        function void note_input(logic kind, logic [87:0] d);
            longint a[3], b[3], c[3], ctr[3], e1[3], e2[3], cr[3];
            longint unsigned mag[3], mx, nrm, lm, q;
            logic ln;
            int s0, s1, s2;
            t_face f;
            if (kind == REQ_VERTEX) begin
                vx[d[9:0]] = d[25:10];
                vy[d[9:0]] = d[41:26];
                vz[d[9:0]] = d[57:42];
                return;
            end
            s0 = d[67:58]; s1 = d[77:68]; s2 = d[87:78];
            a[0] = vx[s0]; a[1] = vy[s0]; a[2] = vz[s0];
            b[0] = vx[s1]; b[1] = vy[s1]; b[2] = vz[s1];
            c[0] = vx[s2]; c[1] = vy[s2]; c[2] = vz[s2];
            for (int i = 0; i < 3; i++) begin
                // SystemVerilog division truncates toward zero, as required.
                ctr[i] = (a[i] + b[i] + c[i]) / 3;
                e1[i] = b[i] - a[i];
                e2[i] = c[i] - a[i];
            end
            cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
            cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
            cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
                if (mag[i] > mx) mx = mag[i];
            end
            f.cx = ctr[0][15:0]; f.cy = ctr[1][15:0]; f.cz = ctr[2][15:0];
            f.degen = (mx == 0);
            if (f.degen) begin
                f.tx = f.cx; f.ty = f.cy; f.tz = f.cz;
            end else begin
                while (mx >= (64'd1 << 30)) begin
                    mx >>= 1;
                    for (int i = 0; i < 3; i++) mag[i] >>= 1;
                end
                while (mx < (64'd1 << 29)) begin
                    mx <<= 1;
                    for (int i = 0; i < 3; i++) mag[i] <<= 1;
                end
                nrm = root64(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
                ln = seg_len < 0;
                lm = ln ? -longint'(seg_len) : longint'(seg_len);
                for (int i = 0; i < 3; i++) begin
                    q = (mag[i] * lm) / nrm;
                    ctr[i] = ctr[i] + (((cr[i] < 0) != ln) ? -longint'(q) : longint'(q));
                end
                f.tx = clip16(ctr[0]); f.ty = clip16(ctr[1]); f.tz = clip16(ctr[2]);
            end
            pending = {pending, f};
        endfunction

        function void check_result(logic [95:0] d, logic dg);
            t_face got, exp_f;
            got = {d[15:0], d[31:16], d[47:32], d[63:48], d[79:64], d[95:80], dg};
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h deg %b", d, dg);
                return;
            end
            exp_f = pending.pop_front();
            if (got !== exp_f) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp c=%h,%h,%h t=%h,%h,%h d=%b",
                        exp_f.cx, exp_f.cy, exp_f.cz, exp_f.tx, exp_f.ty, exp_f.tz,
                        exp_f.degen);
                    $display("         got c=%h,%h,%h t=%h,%h,%h d=%b",
                        got.cx, got.cy, got.cz, got.tx, got.ty, got.tz, got.degen);
                end
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [0:0] s_axis_tuser, m_axis_tuser;
    logic [95:0] m_axis_tdata;
    logic i_cfg_valid, o_cfg_ready;
    logic [CW-1:0] i_cfg_data;

    face_board board;
    int send_idle_pct, recv_stall_pct;
    bit written[VERTEX_COUNT];
    int n_written;
    int slot_list[$];
    int cycles;

    triangle_face_normal_segment_core dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: random stalls applied on the falling edge, checks on the rising edge.
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("tb_triangle_face_normal_segment_core NOT OK");
        $finish;
    end

    // Leaves s_axis_tvalid high after the transfer so items can follow back to back.
    task automatic push_item(logic kind, logic [87:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_input(kind, d);
        @(negedge i_clk);
    endtask

    task automatic write_vertex(int slot, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        push_item(REQ_VERTEX, {30'd0, z, y, x, 10'(slot)});
        if (!written[slot]) begin
            written[slot] = 1;
            slot_list = {slot_list, slot};
        end
    endtask

    task automatic send_triangle(int s0, int s1, int s2);
        push_item(REQ_TRIANGLE, {10'(s2), 10'(s1), 10'(s0), 58'd0});
    endtask

    function automatic int any_slot();
        return slot_list[$urandom_range(slot_list.size() - 1)];
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(0, 2047) - 1024);
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 63) - 32);
        endcase
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    task automatic set_length(logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.seg_len = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 30 || slot_list.size() < 3)
                write_vertex($urandom_range(VERTEX_COUNT - 1), rand_coord(), rand_coord(),
                             rand_coord());
            else
                send_triangle(any_slot(), any_slot(), any_slot());
        end
    endtask

    initial begin
        board = new();
        cycles = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extreme coordinates, both slot ends, degenerate and saturating cases.
        write_vertex(0, 16'h0000, 16'h0000, 16'h0000);
        write_vertex(1, 16'h0100, 16'h0000, 16'h0000);
        write_vertex(2, 16'h0000, 16'h0100, 16'h0000);
        write_vertex(1023, 16'h7fff, 16'h7fff, 16'h7fff);
        write_vertex(512, 16'h8000, 16'h8000, 16'h8000);
        write_vertex(3, 16'h7fff, 16'h8000, 16'h7fff);
        write_vertex(4, 16'h0200, 16'h0000, 16'h0000);
        send_triangle(0, 1, 2);
        send_triangle(0, 2, 1);
        send_triangle(0, 0, 0);
        send_triangle(0, 1, 4);
        send_triangle(1023, 1023, 1023);
        send_triangle(512, 512, 512);
        send_triangle(1023, 512, 3);
        send_triangle(3, 1023, 512);
        send_triangle(1023, 0, 512);
        send_triangle(1, 2, 1023);
        set_length(16'h7fff);
        send_triangle(1023, 512, 3);
        send_triangle(0, 1, 2);
        set_length(16'h8000);
        send_triangle(1023, 512, 3);
        send_triangle(0, 2, 1);
        set_length(16'h0000);
        send_triangle(0, 1, 2);

        set_length(16'h0200);
        random_phase(400);
        send_idle_pct = 80;
        set_length(16'h8000);
        random_phase(300);
        send_idle_pct = 0;
        recv_stall_pct = 80;
        set_length(16'($urandom_range(65535)));
        random_phase(450);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        set_length(16'h7fff);
        random_phase(300);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_length(16'h0001);
        random_phase(250);

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_triangle_face_normal_segment_core OK");
        else
            $display("tb_triangle_face_normal_segment_core NOT OK");
        $finish;
    end
endmodule

// File: files.f
+incdir+src
src/tfn_pkg.sv
src/tfn_geom.sv
src/tfn_isqrt.sv
src/tfn_scale.sv
src/triangle_face_normal_segment_core.sv
verif/tb_triangle_face_normal_segment_core.sv
